@@ design/bmf_pkg.sv @@
// Shared constants, register codes and control types for the 5x5 box mean filter.
// No dependencies; used by every design file through scoped names.
package bmf_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    localparam int WIDTH_BITS    = 11;
    localparam int HEIGHT_BITS   = 16;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam int WIN   = 5;
    localparam int BANKS = 4;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic REQ_PIXEL = 1'b0;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
        logic from_store;
    } t_emit;

endpackage

@@ design/box_mean_filter_5x5.sv @@
// 5x5 box mean filter top: counters, four line-store banks, chain of window cells,
// divide-by-25 pipeline and output skid. Depends on bmf_pkg, bmf_line_bank, bmf_window_cell.
// A result is registered through stage 1, stages 2 to 4 and then the output register.
// Throughput: one item per cycle while o_in_stall is low; the line banks take one read and one write per cycle.
// Reset (synchronous, active low): counters, pipeline and output empty, width 640,
// height 480; line-store contents are not cleared.
module box_mean_filter_5x5 #(
    parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bmf_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bmf_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_req_type,
    input  logic [PIXEL_BITS-1:0]             i_pixel_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [PIXEL_BITS-1:0]             o_pixel_out,
    output logic                              o_last_of_frame
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = bmf_pkg::HEIGHT_BITS;
    localparam int WIN   = bmf_pkg::WIN;
    localparam int BANKS = bmf_pkg::BANKS;
    localparam int CSW   = PIXEL_BITS + 3;
    localparam int SW    = PIXEL_BITS + 5;
    localparam int K     = SW + 5;
    localparam int MW    = SW + 1;
    localparam int PW    = SW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'd24) / 64'd25);

    function automatic logic [WW-1:0] eff_w(input logic [bmf_pkg::WIDTH_BITS-1:0] v);
        logic [WW-1:0] r;
        if (v == '0) begin
            r = WW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            r = WW'(MAX_WIDTH);
        end else begin
            r = WW'(v);
        end
        return r;
    endfunction

    function automatic logic [HW-1:0] eff_h(input logic [HW-1:0] v);
        return (v == '0) ? HW'(1) : v;
    endfunction

    // frame geometry and position counters
    logic [WW-1:0] r_w, n_w;
    logic [HW-1:0] r_h, n_h;
    logic [XW-1:0] r_in_col, n_in_col;
    logic [HW-1:0] r_in_row, n_in_row;
    logic [XW-1:0] r_out_col, n_out_col;
    logic [HW-1:0] r_out_row, n_out_row;

    logic en, accept;
    logic frame_done, is_pix, primed, emit_now, interior_now, last_now;
    logic in_wrap, out_wrap;

    logic                  r_out_valid, n_out_valid;
    logic                  r_sk_valid, n_sk_valid;
    logic [PIXEL_BITS-1:0] r_out_px, r_sk_px;
    logic                  r_out_last, r_sk_last;
    logic                  take, push, load_out, load_sk, out_from_sk;

    assign en         = ~r_sk_valid;
    assign o_in_stall = r_sk_valid;
    assign accept     = i_in_valid & en;

    assign frame_done = (r_in_row >= r_h);
    assign is_pix     = ~frame_done & (i_req_type == bmf_pkg::REQ_PIXEL);
    assign primed     = ((r_in_row >= HW'(3)) && ((r_w != WW'(1)) || (r_in_row >= HW'(4))))
                     || ((r_in_row == HW'(2)) && (r_in_col >= XW'(2)));
    assign emit_now   = frame_done | (is_pix & primed);
    assign interior_now = (r_out_row >= HW'(2)) && (r_out_col >= XW'(2))
                     && ((HW + 1)'(r_out_row) + (HW + 1)'(3) <= (HW + 1)'(r_h))
                     && ((WW + 1)'(r_out_col) + (WW + 1)'(3) <= (WW + 1)'(r_w));
    assign last_now   = (r_out_row == r_h - HW'(1)) && (WW'(r_out_col) == r_w - WW'(1));
    assign in_wrap    = (WW'(r_in_col) + WW'(1)) == r_w;
    assign out_wrap   = (WW'(r_out_col) + WW'(1)) == r_w;

    always_comb begin
        n_w       = r_w;
        n_h       = r_h;
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we) begin
            case (i_cfg_index)
                bmf_pkg::REG_FRAME_WIDTH: begin
                    n_w = eff_w(i_cfg_data[bmf_pkg::WIDTH_BITS-1:0]);
                end
                bmf_pkg::REG_FRAME_HEIGHT: begin
                    n_h = eff_h(i_cfg_data[HW-1:0]);
                end
                default: begin
                end
            endcase
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (accept) begin
            if (emit_now && last_now) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (emit_now) begin
                    if (out_wrap) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + HW'(1);
                    end else begin
                        n_out_col = r_out_col + XW'(1);
                    end
                end
                if (is_pix) begin
                    if (in_wrap) begin
                        n_in_col = '0;
                        n_in_row = r_in_row + HW'(1);
                    end else begin
                        n_in_col = r_in_col + XW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w       <= eff_w(bmf_pkg::WIDTH_BITS'(bmf_pkg::WIDTH_RESET));
            r_h       <= HW'(bmf_pkg::HEIGHT_RESET);
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_w       <= n_w;
            r_h       <= n_h;
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // line store: one bank per row slot, all read at the same column
    logic [BANKS-1:0][PIXEL_BITS-1:0] bank_rd;
    logic [XW-1:0]                    rd_addr;

    assign rd_addr = frame_done ? r_out_col : r_in_col;

    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        bmf_line_bank #(
            .DEPTH      (MAX_WIDTH),
            .PIXEL_BITS (PIXEL_BITS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (accept && is_pix && (r_in_row[1:0] == 2'(b))),
            .i_waddr (r_in_col),
            .i_wdata (i_pixel_in),
            .i_re    (en),
            .i_raddr (rd_addr),
            .o_rdata (bank_rd[b])
        );
    end

    // stage 1: item accepted, bank reads in flight
    bmf_pkg::t_emit        r1_ctl, r2_ctl, r3_ctl, r4_ctl;
    logic                  r1_shift;
    logic [PIXEL_BITS-1:0] r1_pix;
    logic [1:0]            r1_slot, r1_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl   <= '0;
            r1_shift <= 1'b0;
            r2_ctl   <= '0;
            r3_ctl   <= '0;
            r4_ctl   <= '0;
        end else if (en) begin
            r1_shift          <= accept & is_pix;
            r1_ctl.emit       <= accept & emit_now;
            r1_ctl.interior   <= interior_now;
            r1_ctl.last       <= last_now;
            r1_ctl.from_store <= frame_done;
            r2_ctl            <= r1_ctl;
            r3_ctl            <= r2_ctl;
            r4_ctl            <= r3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pix  <= i_pixel_in;
            r1_slot <= r_in_row[1:0];
            r1_sel  <= r_out_row[1:0];
        end
    end

    // new window column: four stored rows, oldest first, then the incoming pixel
    logic [WIN-1:0][PIXEL_BITS-1:0] new_col;
    logic [CSW-1:0]                 new_sum;

    always_comb begin
        new_sum = '0;
        for (int r = 0; r < WIN - 1; r++) begin
            new_col[r] = bank_rd[2'(r1_slot + 2'(r))];
        end
        new_col[WIN-1] = r1_pix;
        for (int r = 0; r < WIN; r++) begin
            new_sum = new_sum + CSW'(new_col[r]);
        end
    end

    logic [WIN-1:0][WIN-1:0][PIXEL_BITS-1:0] cell_col;
    logic [WIN-1:0][CSW-1:0]                 cell_sum;
    logic [WIN-1:0][SW-1:0]                  cell_acc;

    for (genvar c = 0; c < WIN; c++) begin : g_cell
        if (c == WIN - 1) begin : g_head
            bmf_window_cell #(
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .i_clk     (i_clk),
                .i_shift   (en & r1_shift),
                .i_col     (new_col),
                .i_col_sum (new_sum),
                .i_acc     ('0),
                .o_col     (cell_col[c]),
                .o_col_sum (cell_sum[c]),
                .o_acc     (cell_acc[c])
            );
        end else begin : g_body
            bmf_window_cell #(
                .PIXEL_BITS (PIXEL_BITS)
            ) u_cell (
                .i_clk     (i_clk),
                .i_shift   (en & r1_shift),
                .i_col     (cell_col[c+1]),
                .i_col_sum (cell_sum[c+1]),
                .i_acc     (cell_acc[c+1]),
                .o_col     (cell_col[c]),
                .o_col_sum (cell_sum[c]),
                .o_acc     (cell_acc[c])
            );
        end
    end

    // stages 2 to 4: pass-through pick, window sum, multiply by 1/25
    logic [PIXEL_BITS-1:0] r2_store_px, r3_pass, r4_pass;
    logic [SW-1:0]         r3_sum;
    logic [PW-1:0]         r4_prod;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_store_px <= bank_rd[r1_sel];
            r3_sum      <= cell_acc[0];
            r3_pass     <= r2_ctl.from_store ? r2_store_px : cell_col[2][2];
            r4_prod     <= PW'(r3_sum) * PW'(RECIP);
            r4_pass     <= r3_pass;
        end
    end

    logic [PIXEL_BITS-1:0] res_px;
    assign res_px = r4_ctl.interior ? r4_prod[K +: PIXEL_BITS] : r4_pass;

    // output register and skid
    assign take = r_out_valid & ~i_out_stall;
    assign push = en & r4_ctl.emit;

    always_comb begin
        n_out_valid = r_out_valid;
        n_sk_valid  = r_sk_valid;
        load_out    = 1'b0;
        load_sk     = 1'b0;
        out_from_sk = 1'b0;
        if (take) begin
            if (r_sk_valid) begin
                out_from_sk = 1'b1;
                n_sk_valid  = 1'b0;
            end else if (push) begin
                load_out = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid) begin
                load_out    = 1'b1;
                n_out_valid = 1'b1;
            end else begin
                load_sk    = 1'b1;
                n_sk_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sk_valid  <= n_sk_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_from_sk) begin
            r_out_px   <= r_sk_px;
            r_out_last <= r_sk_last;
        end else if (load_out) begin
            r_out_px   <= res_px;
            r_out_last <= r4_ctl.last;
        end
        if (load_sk) begin
            r_sk_px   <= res_px;
            r_sk_last <= r4_ctl.last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_out     = r_out_px;
    assign o_last_of_frame = r_out_last;

endmodule

@@ design/bmf_line_bank.sv @@
// One line-store row: single write port, registered read-first read port.
// Depends on bmf_pkg for the default pixel width.
module bmf_line_bank #(
    parameter int DEPTH      = bmf_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [PIXEL_BITS-1:0]    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [PIXEL_BITS-1:0]    o_rdata
);

    logic [PIXEL_BITS-1:0] r_mem [DEPTH];
    logic [PIXEL_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bmf_window_cell.sv @@
// One column of the 5x5 window: holds five pixels and their sum, shifts to its neighbor,
// and adds its column sum onto the running window sum. Depends on bmf_pkg.
module bmf_window_cell #(
    parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_shift,
    input  logic [bmf_pkg::WIN-1:0][PIXEL_BITS-1:0] i_col,
    input  logic [PIXEL_BITS+2:0]                   i_col_sum,
    input  logic [PIXEL_BITS+4:0]                   i_acc,
    output logic [bmf_pkg::WIN-1:0][PIXEL_BITS-1:0] o_col,
    output logic [PIXEL_BITS+2:0]                   o_col_sum,
    output logic [PIXEL_BITS+4:0]                   o_acc
);

    localparam int SW = PIXEL_BITS + 5;

    logic [bmf_pkg::WIN-1:0][PIXEL_BITS-1:0] r_col;
    logic [PIXEL_BITS+2:0]                   r_sum;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
            r_sum <= i_col_sum;
        end
    end

    assign o_col     = r_col;
    assign o_col_sum = r_sum;
    assign o_acc     = i_acc + SW'(r_sum);

endmodule

@@ design/bmf_checker.sv @@
// Port-level checks for box_mean_filter_5x5 and the bind that attaches them.
// Depends on bmf_pkg and the top level's ports.
module bmf_checker #(
    parameter int PIXEL_BITS = bmf_pkg::PIXEL_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [PIXEL_BITS-1:0] o_pixel_out,
    input logic                  o_last_of_frame
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_pixel_out) && $stable(o_last_of_frame))
        else $error("stalled result item changed");

    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(o_out_valid && i_out_stall))
        else $error("input stall raised without a stalled result");

endmodule

bind box_mean_filter_5x5 bmf_checker #(
    .PIXEL_BITS (PIXEL_BITS)
) u_bmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pixel_out     (o_pixel_out),
    .o_last_of_frame (o_last_of_frame)
);
